/* rtl/cwm_pkg.sv */
// Shared types and constants for the centre-weighted 3x3 median filter.
// No dependencies; compiled first.
package cwm_pkg;

  localparam int unsigned PixW       = 8;
  localparam int unsigned NumNb      = 8;
  localparam int unsigned WeightW    = 4;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned CntW       = 4;
  localparam int unsigned SumW       = 5;

  localparam logic [WeightW-1:0] MaxWeight   = 4'd12;
  localparam logic [WeightW-1:0] WeightReset = 4'd3;

  typedef logic [PixW-1:0]    pix_t;
  typedef logic [WeightW-1:0] weight_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [SumW-1:0]    sum_t;

  // Eight neighbours, raster order with the centre removed
  typedef pix_t [NumNb-1:0] nb_arr_t;

  // Counts of neighbours against the centre
  typedef struct packed {
    cnt_t below;
    cnt_t equal;
  } cmp_cnt_t;

endpackage

/* rtl/cwm_win_if.sv */
// Window channel: valid/ready handshake carrying one 3x3 pixel window per word.
// Depends on cwm_pkg.
interface cwm_win_if;
  import cwm_pkg::*;

  logic valid;
  logic ready;
  pix_t top_left;
  pix_t top_middle;
  pix_t top_right;
  pix_t mid_left;
  pix_t centre_pixel;
  pix_t mid_right;
  pix_t bottom_left;
  pix_t bottom_middle;
  pix_t bottom_right;

  modport source (
    output valid, top_left, top_middle, top_right, mid_left, centre_pixel,
           mid_right, bottom_left, bottom_middle, bottom_right,
    input  ready
  );

  modport sink (
    input  valid, top_left, top_middle, top_right, mid_left, centre_pixel,
           mid_right, bottom_left, bottom_middle, bottom_right,
    output ready
  );
endinterface

/* rtl/cwm_pix_if.sv */
// Pixel channel: valid/ready handshake carrying one filtered pixel per word.
// Depends on cwm_pkg.
interface cwm_pix_if;
  import cwm_pkg::*;

  logic valid;
  logic ready;
  pix_t filtered_pixel;

  modport source (
    output valid, filtered_pixel,
    input  ready
  );

  modport sink (
    input  valid, filtered_pixel,
    output ready
  );
endinterface

/* rtl/cwm_sort.sv */
// Parallel rank sort of the eight neighbours plus counts against the centre.
// Purely combinational; depends on cwm_pkg.
module cwm_sort (
  input  cwm_pkg::nb_arr_t  nb_i,
  input  cwm_pkg::pix_t     centre_i,
  output cwm_pkg::nb_arr_t  sorted_o,
  output cwm_pkg::cmp_cnt_t cnt_o
);
  import cwm_pkg::*;

  idx_t pos [NumNb];

  // Sorted position of each neighbour: smaller ones, plus equal ones earlier
  // in raster order, so every position is taken exactly once
  always_comb begin
    for (int j = 0; j < NumNb; j++) begin
      pos[j] = '0;
      for (int k = 0; k < NumNb; k++) begin
        if (k != j) begin
          if ((nb_i[k] < nb_i[j]) || ((nb_i[k] == nb_i[j]) && (k < j))) begin
            pos[j] = pos[j] + idx_t'(1);
          end
        end
      end
    end
  end

  // Scatter into sorted order; positions are unique so an OR-mux suffices
  always_comb begin
    for (int r = 0; r < NumNb; r++) begin
      sorted_o[r] = '0;
      for (int j = 0; j < NumNb; j++) begin
        if (pos[j] == idx_t'(r)) begin
          sorted_o[r] = sorted_o[r] | nb_i[j];
        end
      end
    end
  end

  // Neighbours strictly below and equal to the centre
  always_comb begin
    cnt_o.below = '0;
    cnt_o.equal = '0;
    for (int j = 0; j < NumNb; j++) begin
      if (nb_i[j] < centre_i) begin
        cnt_o.below = cnt_o.below + cnt_t'(1);
      end else if (nb_i[j] == centre_i) begin
        cnt_o.equal = cnt_o.equal + cnt_t'(1);
      end
    end
  end

endmodule

/* rtl/center_weighted_median_3x3.sv */
// Centre-weighted 3x3 median filter. Each window word yields one filtered pixel:
// the element at rank floor((8+w)/2) of the eight neighbours plus w copies of the
// centre, w being centre_weight (reset 3, values above 12 act as 12). One word is
// taken every clock unless a full result register is held by the receiver; a word
// passes through the input register and then the result register. Both stages
// advance together whenever the result register is empty or being drained.
// Depends on cwm_pkg, cwm_win_if, cwm_pix_if and cwm_sort.
module center_weighted_median_3x3 (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            centre_weight_we_i,
  input  cwm_pkg::weight_t centre_weight_i,
  cwm_win_if.sink         win_i,
  cwm_pix_if.source       pix_o
);
  import cwm_pkg::*;

  logic      adv;
  logic      in_valid_q;
  logic      out_valid_q;
  weight_t   weight_q;
  nb_arr_t   nb_q;
  pix_t      centre_q;
  pix_t      pix_q;
  pix_t      pix_d;
  nb_arr_t   sorted;
  cmp_cnt_t  cnt;
  weight_t   w_sat;
  sum_t      rank;
  sum_t      upper;
  sum_t      hi_idx;

  // Pipeline moves when the result slot is free or being taken
  assign adv         = !out_valid_q || pix_o.ready;
  assign win_i.ready = adv;

  // Control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      weight_q    <= WeightReset;
    end else begin
      if (centre_weight_we_i) begin
        weight_q <= centre_weight_i;
      end
      if (adv) begin
        in_valid_q  <= win_i.valid;
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (adv && win_i.valid) begin
      nb_q[0]  <= win_i.top_left;
      nb_q[1]  <= win_i.top_middle;
      nb_q[2]  <= win_i.top_right;
      nb_q[3]  <= win_i.mid_left;
      nb_q[4]  <= win_i.mid_right;
      nb_q[5]  <= win_i.bottom_left;
      nb_q[6]  <= win_i.bottom_middle;
      nb_q[7]  <= win_i.bottom_right;
      centre_q <= win_i.centre_pixel;
    end
  end

  cwm_sort u_sort (
    .nb_i     (nb_q),
    .centre_i (centre_q),
    .sorted_o (sorted),
    .cnt_o    (cnt)
  );

  // Rank selection: below the centre run, inside it, or above it
  always_comb begin
    w_sat  = (weight_q > MaxWeight) ? MaxWeight : weight_q;
    rank   = (sum_t'(NumNb) + sum_t'(w_sat)) >> 1;
    upper  = sum_t'(cnt.below) + sum_t'(cnt.equal) + sum_t'(w_sat);
    hi_idx = rank - sum_t'(w_sat);
    if (rank < sum_t'(cnt.below)) begin
      pix_d = sorted[rank[IdxW-1:0]];
    end else if (rank < upper) begin
      pix_d = centre_q;
    end else begin
      pix_d = sorted[hi_idx[IdxW-1:0]];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv && in_valid_q) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o.valid          = out_valid_q;
  assign pix_o.filtered_pixel = pix_q;

endmodule

/* bench/tb.sv */
// Self-checking bench for center_weighted_median_3x3: windows in, filtered pixels out,
// each word checked against a weighted-median predictor. Depends on cwm_pkg,
// cwm_win_if, cwm_pix_if and the filter RTL.
module tb;
  import cwm_pkg::*;

  localparam int StallLimit = 5000;

  // Raster order, index 4 is the centre
  typedef pix_t [8:0] window_t;

  logic    clk_i;
  logic    rst_ni;
  logic    weight_we;
  weight_t weight_val;

  cwm_win_if win ();
  cwm_pix_if pix ();

  center_weighted_median_3x3 dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .centre_weight_we_i (weight_we),
    .centre_weight_i    (weight_val),
    .win_i              (win),
    .pix_o              (pix)
  );

  pix_t    expected_pixels[$];
  weight_t cur_weight;
  int      error_count;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      stall_left;
  int      quiet_cycles;

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Weighted median: sort neighbours plus the centre copies, take the upper middle
  function automatic pix_t weighted_median(window_t w, weight_t wt);
    pix_t        pool[20];
    pix_t        tmp;
    int unsigned eff;
    int          n;
    int          i;
    int          j;
    eff = (wt > MaxWeight) ? MaxWeight : wt;
    n = 0;
    for (i = 0; i < 9; i++) begin
      if (i != 4) begin
        pool[n] = w[i];
        n++;
      end
    end
    for (i = 0; i < int'(eff); i++) begin
      pool[n] = w[4];
      n++;
    end
    for (i = 1; i < n; i++) begin
      tmp = pool[i];
      j = i - 1;
      while (j >= 0 && pool[j] > tmp) begin
        pool[j + 1] = pool[j];
        j--;
      end
      pool[j + 1] = tmp;
    end
    return pool[(8 + eff) / 2];
  endfunction

  function automatic window_t win9(pix_t tl, pix_t tm, pix_t tr, pix_t ml, pix_t c,
                                   pix_t mr, pix_t bl, pix_t bm, pix_t br);
    window_t w;
    w[0] = tl; w[1] = tm; w[2] = tr;
    w[3] = ml; w[4] = c;  w[5] = mr;
    w[6] = bl; w[7] = bm; w[8] = br;
    return w;
  endfunction

  // Random window: plain noise, near-flat patches with ties, centre ties, extremes
  function automatic window_t rand_window();
    window_t w;
    pix_t    base;
    int      i;
    base = pix_t'($urandom_range(255));
    for (i = 0; i < 9; i++) w[i] = pix_t'($urandom_range(255));
    case ($urandom_range(3))
      0: ;
      1: begin
        for (i = 0; i < 9; i++) w[i] = base + pix_t'($urandom_range(3));
      end
      2: begin
        for (i = 0; i < 9; i++) begin
          if ($urandom_range(1) == 0) w[i] = w[4];
        end
      end
      default: begin
        for (i = 0; i < 9; i++) begin
          case ($urandom_range(2))
            0: w[i] = 8'h00;
            1: w[i] = 8'hFF;
            default: ;
          endcase
        end
      end
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string what, pix_t got, pix_t want);
    $display("tb: mismatch (%s): got %0d, want %0d", what, got, want);
    error_count++;
  endtask

  // Offer one window word and hold it until accepted
  task automatic send_window(window_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      win.valid <= 1'b0;
    end
    @(negedge clk_i);
    win.valid         <= 1'b1;
    win.top_left      <= w[0];
    win.top_middle    <= w[1];
    win.top_right     <= w[2];
    win.mid_left      <= w[3];
    win.centre_pixel  <= w[4];
    win.mid_right     <= w[5];
    win.bottom_left   <= w[6];
    win.bottom_middle <= w[7];
    win.bottom_right  <= w[8];
    do @(posedge clk_i); while (!win.ready);
    expected_pixels.push_back(weighted_median(w, cur_weight));
  endtask

  // Stop offering and wait for every pending pixel, plus the pipeline depth
  task automatic drain();
    @(negedge clk_i);
    win.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Weight write, only with the filter empty
  task automatic set_weight(weight_t w);
    drain();
    @(negedge clk_i);
    weight_we  <= 1'b1;
    weight_val <= w;
    @(negedge clk_i);
    weight_we  <= 1'b0;
    cur_weight = w;
  endtask

  // Extremes, tie patterns and the even-count upper median over a spread of weights
  task automatic test_directed();
    weight_t wts[5];
    int      k;
    wts = '{4'd0, 4'd4, 4'd9, 4'd12, 4'd15};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // reset weight
    send_window(win9(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_window(win9(255, 255, 255, 255, 255, 255, 255, 255, 255));
    send_window(win9(255, 255, 255, 255, 0, 255, 255, 255, 255));
    send_window(win9(0, 0, 0, 0, 255, 0, 0, 0, 0));
    send_window(win9(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
    send_window(win9(1, 2, 3, 4, 5, 6, 7, 8, 9));
    for (k = 0; k < 5; k++) begin
      set_weight(wts[k]);
      // centre splits neighbours four and four
      send_window(win9(1, 2, 3, 4, 5, 6, 7, 8, 9));
      send_window(win9(200, 190, 180, 170, 0, 160, 150, 140, 130));
      send_window(win9(7, 7, 3, 7, 7, 250, 7, 1, 7));
    end
  endtask

  // Random windows, weight changed every hundred words
  task automatic test_random(int n_items, int s_pct, int r_pct);
    int i;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (i = 0; i < n_items; i++) begin
      if (i % 100 == 0) set_weight(weight_t'($urandom_range(15)));
      send_window(rand_window());
    end
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left = 300;
    for (i = 0; i < 24; i++) send_window(rand_window());
  endtask

  // Sender pauses until all pending pixels are out, then resumes
  task automatic test_drain_pause();
    int i;
    send_idle_pct = 10;
    recv_idle_pct = 40;
    for (i = 0; i < 12; i++) send_window(rand_window());
    drain();
    for (i = 0; i < 12; i++) send_window(rand_window());
  endtask

  // Receiver ready, with random idling and counted hold-off
  initial begin
    pix.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        pix.ready <= 1'b0;
      end else begin
        pix.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    pix_t want;
    if (rst_ni && pix.valid && pix.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected word", pix.filtered_pixel, 8'h00);
      end else begin
        want = expected_pixels.pop_front();
        if (pix.filtered_pixel !== want) begin
          report_mismatch("filtered_pixel", pix.filtered_pixel, want);
        end
      end
    end
  end

  // Watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if ((win.valid && win.ready) || (pix.valid && pix.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("tb: watchdog expired");
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sequence
  initial begin
    error_count   = 0;
    quiet_cycles  = 0;
    stall_left    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_weight    = WeightReset;
    rst_ni        = 1'b0;
    weight_we     = 1'b0;
    weight_val    = '0;
    win.valid         = 1'b0;
    win.top_left      = '0;
    win.top_middle    = '0;
    win.top_right     = '0;
    win.mid_left      = '0;
    win.centre_pixel  = '0;
    win.mid_right     = '0;
    win.bottom_left   = '0;
    win.bottom_middle = '0;
    win.bottom_right  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(350, 31, 70);
    test_random(350, 70, 31);
    test_random(300, 0, 0);
    test_backpressure();
    test_drain_pause();

    drain();
    repeat (8) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      report_mismatch("pixel never arrived", 8'h00, expected_pixels[0]);
    end
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
